[hdl/vpv_pkg.sv]
package vpv_pkg;

    localparam int FRAC_BITS = 16;

    localparam int CW       = 32;            // coordinate and coefficient width
    localparam int PW       = 2 * CW;        // exact product
    localparam int DW       = 64;            // reduced clip coordinate
    localparam int ROWS     = 3;             // clip x, y, w
    localparam int W_ROW    = 2;
    localparam int AXES     = 2;
    localparam int NDC_EXP  = 46;            // magnitude clamp of x/w
    localparam int QW       = NDC_EXP + 1;   // quotient bits, one per divider stage
    localparam int DIV_SHIFT = QW - FRAC_BITS;
    localparam int NW       = QW + 1;        // signed n + 1
    localparam int MSPLIT   = NW / 2;
    localparam int LO_W     = MSPLIT + 1;
    localparam int HI_W     = NW - MSPLIT;
    localparam int VP_W     = 16;
    localparam int SPAN_W   = VP_W + 1;
    localparam int PLO_W    = LO_W + SPAN_W;
    localparam int PHI_W    = HI_W + SPAN_W;
    localparam int VW       = NW + SPAN_W + 1;
    localparam int VPR_W    = 2 * VP_W;

    localparam logic [QW-1:0] NDC_LIMIT = {1'b1, {NDC_EXP{1'b0}}};
    localparam logic [NW-1:0] N_ONE     = NW'(1) << FRAC_BITS;
    localparam logic [CW-1:0] COEF_ONE  = CW'(1) << FRAC_BITS;

    localparam logic [PW-1:0]    ROW0_LO_RST = {COEF_ONE, {CW{1'b0}}};
    localparam logic [PW-1:0]    ROW1_LO_RST = {{CW{1'b0}}, COEF_ONE};
    localparam logic [PW-1:0]    ROW3_LO_RST = {PW{1'b0}};
    localparam logic [PW-1:0]    ROW3_HI_RST = {{CW{1'b0}}, COEF_ONE};
    localparam logic [PW-1:0]    ROW_HI_RST  = {PW{1'b0}};
    localparam logic [VPR_W-1:0] VIEW_LO_RST = {VPR_W{1'b0}};
    localparam logic [VPR_W-1:0] VIEW_HI_RST = {VP_W'(256), VP_W'(256)};

    typedef enum logic [2:0] {
        REG_ROW0_LO = 3'd0,
        REG_ROW0_HI = 3'd1,
        REG_ROW1_LO = 3'd2,
        REG_ROW1_HI = 3'd3,
        REG_ROW3_LO = 3'd4,
        REG_ROW3_HI = 3'd5,
        REG_VIEW_LO = 3'd6,
        REG_VIEW_HI = 3'd7
    } vpv_reg_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_W_ZERO = 2'd1,
        ST_SAT    = 2'd2
    } vpv_status_t;

    typedef struct packed {
        logic [DW-1:0] rem;
        logic [QW-1:0] qd;     // dividend bits shift out at the top, quotient enters below
        logic          ovf;
        logic          neg;
        logic          zero;
    } vpv_axis_t;

    typedef struct packed {
        logic [DW-1:0] den;
        logic          wneg;
        logic          wzero;
        vpv_axis_t     ax;
        vpv_axis_t     ay;
    } vpv_div_t;

endpackage

[hdl/vertex_project_to_viewport_unit.sv]
// Channel  Handshake                 Payload
// -------  ------------------------  --------------------------------------------
// s_       s_tvalid / s_tready       s_tdata: point_x, point_y, point_z
// m_       m_tvalid / m_tready       m_tdata: screen_x, screen_y; m_tuser: status
// cfg_     cfg_valid / cfg_ready     cfg_index, cfg_data (always ready)
//
// One point per cycle while the output queue is not full. The pipeline has five stages
// of multiply, sum, absolute value and divide set-up, 47 divider stages (one quotient
// bit each), four stages of viewport mapping, then a two-beat output queue.
// Reset clears all valid bits and the queue; the matrix and viewport take their
// reset values. The whole pipeline holds while the output queue is full, so a
// waiting beat on m_ never blocks s_ until the queue has filled.
module vertex_project_to_viewport_unit
    import vpv_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [95:0]   s_tdata,    // point_x, point_y, point_z
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [63:0]   m_tdata,    // screen_x, screen_y
    output logic [1:0]    m_tuser,    // status
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [2:0]    cfg_index,
    input  logic [63:0]   cfg_data
);

    typedef struct packed {
        logic            wzero;
        logic [AXES-1:0] neg;
        logic [AXES-1:0] zero;
    } vpv_side_t;

    typedef struct packed {
        logic [CW-1:0] screen_x;
        logic [CW-1:0] screen_y;
        vpv_status_t   status;
    } vpv_out_t;

    localparam logic signed [VW-1:0] OUT_MAX_V = (VW'(1) << (CW - 1)) - VW'(1);
    localparam logic signed [VW-1:0] OUT_MIN_V = ~OUT_MAX_V;

    // configuration
    logic [PW-1:0]    row_lo_reg [ROWS];
    logic [PW-1:0]    row_hi_reg [ROWS];
    logic [VPR_W-1:0] view_lo_reg;
    logic [VPR_W-1:0] view_hi_reg;
    logic [VP_W-1:0]  vp_c0 [AXES];
    logic [VP_W-1:0]  vp_c1 [AXES];
    logic signed [SPAN_W-1:0] span_s [AXES];

    // pipeline
    logic pipe_en;
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic s6_valid_reg, s7_valid_reg, s8_valid_reg, s9_valid_reg;

    logic signed [PW-1:0] prod_reg  [ROWS][4];
    logic signed [PW-1:0] prod_next [ROWS][4];
    logic [PW:0]          sum01_reg [ROWS];
    logic [PW:0]          sum23_reg [ROWS];
    logic [PW:0]          sum01_next [ROWS];
    logic [PW:0]          sum23_next [ROWS];
    logic [DW-1:0]        clip_reg  [ROWS];
    logic [DW-1:0]        clip_next [ROWS];
    logic [PW+1:0]        clip_sum  [ROWS];
    logic [DW-1:0]        abs_reg   [ROWS];
    logic [DW-1:0]        abs_next  [ROWS];
    logic [ROWS-1:0]      neg_reg, neg_next;
    logic [ROWS-1:0]      zero_reg, zero_next;
    vpv_div_t             div0_reg;
    vpv_div_t             div0_next;

    logic     div_valid [QW+1];
    vpv_div_t div_data  [QW+1];

    logic [NW-1:0]             n1_reg  [AXES];
    logic [NW-1:0]             n1_next [AXES];
    logic [QW-1:0]             mag     [AXES];
    logic                      qneg    [AXES];
    logic signed [LO_W-1:0]    lo_s    [AXES];
    logic signed [HI_W-1:0]    hi_s    [AXES];
    logic signed [PLO_W-1:0]   plo_reg [AXES];
    logic signed [PLO_W-1:0]   plo_next [AXES];
    logic signed [PHI_W-1:0]   phi_reg [AXES];
    logic signed [PHI_W-1:0]   phi_next [AXES];
    logic signed [VW-1:0]      lo_ext  [AXES];
    logic signed [VW-1:0]      hi_ext  [AXES];
    logic signed [VW-1:0]      mprod_reg  [AXES];
    logic signed [VW-1:0]      mprod_next [AXES];
    logic signed [VW-1:0]      c0_ext  [AXES];
    logic signed [VW-1:0]      v_reg   [AXES];
    logic signed [VW-1:0]      v_next  [AXES];
    vpv_side_t side6_reg, side6_next, side7_reg, side8_reg, side9_reg;

    // output queue
    logic [CW-1:0]  scr_val [AXES];
    logic [AXES-1:0] sat;
    logic           span_pos [AXES];
    logic           span_neg [AXES];
    vpv_out_t       res_next;
    vpv_out_t       fifo_reg [2];
    logic           wr_ptr_reg, rd_ptr_reg;
    logic [1:0]     count_reg;
    logic           push, pop;

    function automatic logic signed [PW-1:0] mul_s(logic [CW-1:0] a, logic [CW-1:0] b);
        logic signed [CW-1:0] sa;
        logic signed [CW-1:0] sb;
        logic signed [PW-1:0] p;
        sa = a;
        sb = b;
        p  = sa * sb;
        return p;
    endfunction

    function automatic logic signed [PW-1:0] coef_scaled(logic [CW-1:0] a);
        logic signed [CW-1:0] sa;
        logic signed [PW-1:0] e;
        sa = a;
        e  = sa;
        return e <<< FRAC_BITS;
    endfunction

    // ---------------------------------------------------------------- config
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_lo_reg[0] <= ROW0_LO_RST;
            row_hi_reg[0] <= ROW_HI_RST;
            row_lo_reg[1] <= ROW1_LO_RST;
            row_hi_reg[1] <= ROW_HI_RST;
            row_lo_reg[2] <= ROW3_LO_RST;
            row_hi_reg[2] <= ROW3_HI_RST;
            view_lo_reg   <= VIEW_LO_RST;
            view_hi_reg   <= VIEW_HI_RST;
        end
        else if (cfg_valid)
        begin
            unique case (vpv_reg_t'(cfg_index))
                REG_ROW0_LO: row_lo_reg[0] <= cfg_data;
                REG_ROW0_HI: row_hi_reg[0] <= cfg_data;
                REG_ROW1_LO: row_lo_reg[1] <= cfg_data;
                REG_ROW1_HI: row_hi_reg[1] <= cfg_data;
                REG_ROW3_LO: row_lo_reg[2] <= cfg_data;
                REG_ROW3_HI: row_hi_reg[2] <= cfg_data;
                REG_VIEW_LO: view_lo_reg   <= cfg_data[VPR_W-1:0];
                REG_VIEW_HI: view_hi_reg   <= cfg_data[VPR_W-1:0];
            endcase
        end
    end

    assign vp_c0[0] = view_lo_reg[VPR_W-1:VP_W];
    assign vp_c0[1] = view_lo_reg[VP_W-1:0];
    assign vp_c1[0] = view_hi_reg[VPR_W-1:VP_W];
    assign vp_c1[1] = view_hi_reg[VP_W-1:0];

    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            span_s[a]   = {1'b0, vp_c1[a]} - {1'b0, vp_c0[a]};
            span_pos[a] = !span_s[a][SPAN_W-1] && (span_s[a] != '0);
            span_neg[a] = span_s[a][SPAN_W-1];
        end
    end

    // ---------------------------------------------------------------- stall
    assign pipe_en  = (count_reg != 2'd2);
    assign s_tready = pipe_en;

    // stage 1: exact products
    always_comb
    begin
        for (int r = 0; r < ROWS; r++)
        begin
            prod_next[r][0] = mul_s(row_lo_reg[r][PW-1:CW], s_tdata[CW-1:0]);
            prod_next[r][1] = mul_s(row_lo_reg[r][CW-1:0], s_tdata[2*CW-1:CW]);
            prod_next[r][2] = mul_s(row_hi_reg[r][PW-1:CW], s_tdata[3*CW-1:2*CW]);
            prod_next[r][3] = coef_scaled(row_hi_reg[r][CW-1:0]);
        end
    end

    // stage 2: pair sums; stage 3: row sum, floored by four
    always_comb
    begin
        for (int r = 0; r < ROWS; r++)
        begin
            sum01_next[r] = {prod_reg[r][0][PW-1], prod_reg[r][0]}
                          + {prod_reg[r][1][PW-1], prod_reg[r][1]};
            sum23_next[r] = {prod_reg[r][2][PW-1], prod_reg[r][2]}
                          + {prod_reg[r][3][PW-1], prod_reg[r][3]};
            clip_sum[r]   = {sum01_reg[r][PW], sum01_reg[r]}
                          + {sum23_reg[r][PW], sum23_reg[r]};
            clip_next[r]  = clip_sum[r][PW+1:2];
        end
    end

    // stage 4: sign and magnitude
    always_comb
    begin
        for (int r = 0; r < ROWS; r++)
        begin
            neg_next[r]  = clip_reg[r][DW-1];
            zero_next[r] = (clip_reg[r] == '0);
            abs_next[r]  = clip_reg[r][DW-1] ? (DW'(0) - clip_reg[r]) : clip_reg[r];
        end
    end

    // stage 5: clamp check and divider set-up
    always_comb
    begin
        logic [DW-1:0] hi_x;
        logic [DW-1:0] hi_y;
        logic [DW-1:0] sh_x;
        logic [DW-1:0] sh_y;
        hi_x = abs_reg[0] >> DIV_SHIFT;
        hi_y = abs_reg[1] >> DIV_SHIFT;
        sh_x = abs_reg[0] << FRAC_BITS;
        sh_y = abs_reg[1] << FRAC_BITS;
        div0_next.den     = abs_reg[W_ROW];
        div0_next.wneg    = neg_reg[W_ROW];
        div0_next.wzero   = zero_reg[W_ROW];
        div0_next.ax.rem  = hi_x;
        div0_next.ax.qd   = sh_x[QW-1:0];
        div0_next.ax.ovf  = (hi_x >= abs_reg[W_ROW]);
        div0_next.ax.neg  = neg_reg[0];
        div0_next.ax.zero = zero_reg[0];
        div0_next.ay.rem  = hi_y;
        div0_next.ay.qd   = sh_y[QW-1:0];
        div0_next.ay.ovf  = (hi_y >= abs_reg[W_ROW]);
        div0_next.ay.neg  = neg_reg[1];
        div0_next.ay.zero = zero_reg[1];
    end

    assign div_valid[0] = s5_valid_reg;
    assign div_data[0]  = div0_reg;

    for (genvar g = 0; g < QW; g++)
    begin : g_div
        vpv_div_stage u_stage
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (pipe_en),
            .in_valid  (div_valid[g]),
            .in_data   (div_data[g]),
            .out_valid (div_valid[g+1]),
            .out_data  (div_data[g+1])
        );
    end

    // stage 6: clamp, apply sign, add one
    always_comb
    begin
        mag[0]  = (div_data[QW].ax.ovf || div_data[QW].ax.qd[QW-1]) ?
                  NDC_LIMIT : div_data[QW].ax.qd;
        mag[1]  = (div_data[QW].ay.ovf || div_data[QW].ay.qd[QW-1]) ?
                  NDC_LIMIT : div_data[QW].ay.qd;
        qneg[0] = div_data[QW].ax.neg ^ div_data[QW].wneg;
        qneg[1] = div_data[QW].ay.neg ^ div_data[QW].wneg;
        for (int a = 0; a < AXES; a++)
        begin
            n1_next[a] = qneg[a] ? (N_ONE - {1'b0, mag[a]}) : (N_ONE + {1'b0, mag[a]});
        end
        side6_next.wzero = div_data[QW].wzero;
        side6_next.neg   = {div_data[QW].ay.neg, div_data[QW].ax.neg};
        side6_next.zero  = {div_data[QW].ay.zero, div_data[QW].ax.zero};
    end

    // stage 7: split multiply by span; stage 8: join; stage 9: halve, add corner
    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            lo_s[a]       = {1'b0, n1_reg[a][MSPLIT-1:0]};
            hi_s[a]       = n1_reg[a][NW-1:MSPLIT];
            plo_next[a]   = lo_s[a] * span_s[a];
            phi_next[a]   = hi_s[a] * span_s[a];
            lo_ext[a]     = plo_reg[a];
            hi_ext[a]     = phi_reg[a];
            mprod_next[a] = (hi_ext[a] <<< MSPLIT) + lo_ext[a];
            c0_ext[a]     = VW'(vp_c0[a]) << FRAC_BITS;
            v_next[a]     = (mprod_reg[a] >>> 1) + c0_ext[a];
        end
    end

    // final: saturate, zero-w override, status
    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            sat[a] = 1'b0;
            if (side9_reg.wzero)
            begin
                scr_val[a] = ((side9_reg.neg[a] && span_pos[a]) ||
                              (!side9_reg.neg[a] && !side9_reg.zero[a] && span_neg[a])) ?
                             OUT_MIN_V[CW-1:0] : OUT_MAX_V[CW-1:0];
            end
            else if (v_reg[a] > OUT_MAX_V)
            begin
                scr_val[a] = OUT_MAX_V[CW-1:0];
                sat[a]     = 1'b1;
            end
            else if (v_reg[a] < OUT_MIN_V)
            begin
                scr_val[a] = OUT_MIN_V[CW-1:0];
                sat[a]     = 1'b1;
            end
            else
            begin
                scr_val[a] = v_reg[a][CW-1:0];
            end
        end
        res_next.screen_x = scr_val[0];
        res_next.screen_y = scr_val[1];
        priority if (side9_reg.wzero)
            res_next.status = ST_W_ZERO;
        else if (sat != '0)
            res_next.status = ST_SAT;
        else
            res_next.status = ST_OK;
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
            s8_valid_reg <= 1'b0;
            s9_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            s1_valid_reg <= s_tvalid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= div_valid[QW];
            s7_valid_reg <= s6_valid_reg;
            s8_valid_reg <= s7_valid_reg;
            s9_valid_reg <= s8_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            prod_reg  <= prod_next;
            sum01_reg <= sum01_next;
            sum23_reg <= sum23_next;
            clip_reg  <= clip_next;
            abs_reg   <= abs_next;
            neg_reg   <= neg_next;
            zero_reg  <= zero_next;
            div0_reg  <= div0_next;
            n1_reg    <= n1_next;
            side6_reg <= side6_next;
            plo_reg   <= plo_next;
            phi_reg   <= phi_next;
            side7_reg <= side6_reg;
            mprod_reg <= mprod_next;
            side8_reg <= side7_reg;
            v_reg     <= v_next;
            side9_reg <= side8_reg;
        end
    end

    // ---------------------------------------------------------------- output queue
    assign push = pipe_en && s9_valid_reg;
    assign pop  = m_tvalid && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_ptr_reg] <= res_next;
    end

    assign m_tvalid = (count_reg != 2'd0);
    assign m_tdata  = {fifo_reg[rd_ptr_reg].screen_y, fifo_reg[rd_ptr_reg].screen_x};
    assign m_tuser  = fifo_reg[rd_ptr_reg].status;

endmodule

[hdl/vpv_div_stage.sv]
module vpv_div_stage
    import vpv_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  logic     in_valid,
    input  vpv_div_t in_data,
    output logic     out_valid,
    output vpv_div_t out_data
);

    logic     valid_reg;
    vpv_div_t data_reg;
    vpv_div_t data_next;

    // one restoring step: bring in the next dividend bit, subtract if it fits
    function automatic vpv_axis_t step_axis(vpv_axis_t a, logic [DW-1:0] den);
        logic [DW:0] trial;
        vpv_axis_t   r;
        r     = a;
        trial = {a.rem, a.qd[QW-1]};
        if (trial >= {1'b0, den})
        begin
            trial = trial - {1'b0, den};
            r.qd  = {a.qd[QW-2:0], 1'b1};
        end
        else
        begin
            r.qd  = {a.qd[QW-2:0], 1'b0};
        end
        r.rem = trial[DW-1:0];
        return r;
    endfunction

    always_comb
    begin
        data_next    = in_data;
        data_next.ax = step_axis(in_data.ax, in_data.den);
        data_next.ay = step_axis(in_data.ay, in_data.den);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
